// ===== sv/hcpg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and helper functions for the cubic Hermite curve
// point generator. No dependencies; every other file imports this package.
package hcpg_pkg;

    localparam int COORD_W = 12;
    localparam int COEF_W  = 16;
    localparam int ACC_W   = 42;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;
    localparam int AXES    = 3;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 12'sd2047;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -12'sd2048;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // Hermite coefficients of one axis: A*u^3 + B*u^2 + C*u + D.
    typedef struct packed {
        coef_t  coef_a;
        coef_t  coef_b;
        coord_t coef_c;
        coord_t coef_d;
    } axis_coef_t;

    // One queued segment: coefficients for x, y and z.
    typedef struct packed {
        axis_coef_t [AXES-1:0] axis;
    } seg_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    function automatic coef_t coord_to_coef(input coord_t v);
        return {{(COEF_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic acc_t coord_to_acc(input coord_t v);
        return {{(ACC_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic acc_t coef_to_acc(input coef_t v);
        return {{(ACC_W-COEF_W){v[COEF_W-1]}}, v};
    endfunction

endpackage

// ===== sv/hcpg_in_if.sv =====
`timescale 1ns / 1ps
// Input channel: one control point with its tangent per beat.
// Depends on hcpg_pkg for the coordinate type.
interface hcpg_in_if import hcpg_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   start_new;
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    coord_t tangent_x;
    coord_t tangent_y;
    coord_t tangent_z;

    modport source (
        output valid, start_new, point_x, point_y, point_z,
               tangent_x, tangent_y, tangent_z,
        input  ready
    );

    modport sink (
        input  valid, start_new, point_x, point_y, point_z,
               tangent_x, tangent_y, tangent_z,
        output ready
    );
endinterface

// ===== sv/hcpg_out_if.sv =====
`timescale 1ns / 1ps
// Output channel: one curve point per beat with clip and end-of-segment flags.
// Depends on hcpg_pkg for the coordinate type.
interface hcpg_out_if import hcpg_pkg::*; ();
    logic   valid;
    logic   ready;
    coord_t curve_x;
    coord_t curve_y;
    coord_t curve_z;
    logic   clipped;
    logic   last_point;

    modport source (
        output valid, curve_x, curve_y, curve_z, clipped, last_point,
        input  ready
    );

    modport sink (
        input  valid, curve_x, curve_y, curve_z, clipped, last_point,
        output ready
    );
endinterface

// ===== sv/hcpg_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts control points, keeps the previous point/tangent pair
// and pushes Hermite coefficients of each segment. Depends on hcpg_pkg, hcpg_in_if.
module hcpg_front import hcpg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    hcpg_in_if.sink     ctrl_pts,
    input  logic        q_full,
    output logic        push,
    output seg_t        push_data
);

    coord_t prev_point_reg   [AXES];
    coord_t prev_tangent_reg [AXES];
    logic   have_prev_reg;

    coord_t new_point   [AXES];
    coord_t new_tangent [AXES];
    logic   accept;

    assign new_point[0]   = ctrl_pts.point_x;
    assign new_point[1]   = ctrl_pts.point_y;
    assign new_point[2]   = ctrl_pts.point_z;
    assign new_tangent[0] = ctrl_pts.tangent_x;
    assign new_tangent[1] = ctrl_pts.tangent_y;
    assign new_tangent[2] = ctrl_pts.tangent_z;

    assign ctrl_pts.ready = !q_full;
    assign accept         = ctrl_pts.valid && !q_full;
    // An item makes a segment only when a stored pair exists and no restart is asked.
    assign push           = accept && !ctrl_pts.start_new && have_prev_reg;

    always_comb
    begin
        coef_t p0, p1, t0, t1, dp;
        for (int i = 0; i < AXES; i++)
        begin
            p0 = coord_to_coef(prev_point_reg[i]);
            p1 = coord_to_coef(new_point[i]);
            t0 = coord_to_coef(prev_tangent_reg[i]);
            t1 = coord_to_coef(new_tangent[i]);
            dp = p1 - p0;
            push_data.axis[i].coef_a = t0 + t1 - (dp <<< 1);
            push_data.axis[i].coef_b = (dp <<< 1) + dp - (t0 <<< 1) - t1;
            push_data.axis[i].coef_c = prev_tangent_reg[i];
            push_data.axis[i].coef_d = prev_point_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            for (int i = 0; i < AXES; i++)
            begin
                prev_point_reg[i]   <= '0;
                prev_tangent_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            have_prev_reg <= 1'b1;
            for (int i = 0; i < AXES; i++)
            begin
                prev_point_reg[i]   <= new_point[i];
                prev_tangent_reg[i] <= new_tangent[i];
            end
        end
    end

endmodule

// ===== sv/hcpg_queue.sv =====
`timescale 1ns / 1ps
// Short segment queue between the front and back ends.
// Depends on hcpg_pkg for the segment type and depth.
module hcpg_queue import hcpg_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  seg_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output seg_t pop_data
);

    seg_t                 mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== sv/hcpg_back.sv =====
`timescale 1ns / 1ps
// Back end: evaluates a segment by forward differences, one point per cycle unless
// stalled, then scales, truncates toward zero and clamps. Depends on hcpg_pkg, hcpg_out_if.
module hcpg_back import hcpg_pkg::*; #(
    parameter int STEPS_LOG2 = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  seg_t        q_data,
    output logic        pop,
    hcpg_out_if.source  curve_pts
);

    localparam int SH    = 3 * STEPS_LOG2;
    localparam int K_W   = STEPS_LOG2 + 1;
    localparam int STEPS = 1 << STEPS_LOG2;
    localparam acc_t BIAS = acc_t'((1 << SH) - 1);
    localparam acc_t HI   = acc_t'(2047);
    localparam acc_t LO   = -acc_t'(2048);

    back_state_t state_reg, state_next;

    acc_t n_reg  [AXES];
    acc_t d1_reg [AXES];
    acc_t d2_reg [AXES];
    acc_t d3_reg [AXES];
    logic [K_W-1:0] k_reg;

    logic   out_valid_reg;
    coord_t out_coord_reg [AXES];
    logic   out_clip_reg;
    logic   out_last_reg;

    logic   advance;
    logic   last_k;
    coord_t pt     [AXES];
    logic   clip   [AXES];

    assign last_k  = (k_reg == K_W'(STEPS));
    assign advance = (state_reg == BK_RUN) && (!out_valid_reg || curve_pts.ready);

    // Scale by 2^-SH with truncation toward zero, then clamp.
    always_comb
    begin
        acc_t biased, q;
        for (int i = 0; i < AXES; i++)
        begin
            biased = n_reg[i] + (n_reg[i][ACC_W-1] ? BIAS : '0);
            q      = biased >>> SH;
            clip[i] = 1'b1;
            if (q > HI)
            begin
                pt[i] = COORD_MAX;
            end
            else if (q < LO)
            begin
                pt[i] = COORD_MIN;
            end
            else
            begin
                pt[i]   = q[COORD_W-1:0];
                clip[i] = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (advance && last_k)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        case (state_reg)
            BK_IDLE: pop = q_valid;
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                k_reg <= '0;
            end
            else if (advance)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (curve_pts.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Difference registers: N(k) = A k^3 + B S k^2 + C S^2 k + D S^3.
    always_ff @(posedge clk)
    begin
        acc_t a, b, c, six_a;
        for (int i = 0; i < AXES; i++)
        begin
            a     = coef_to_acc(q_data.axis[i].coef_a);
            b     = coef_to_acc(q_data.axis[i].coef_b);
            c     = coord_to_acc(q_data.axis[i].coef_c);
            six_a = (a <<< 2) + (a <<< 1);
            if (pop)
            begin
                n_reg[i]  <= coord_to_acc(q_data.axis[i].coef_d) <<< SH;
                d1_reg[i] <= a + (b <<< STEPS_LOG2) + (c <<< (2 * STEPS_LOG2));
                d2_reg[i] <= six_a + (b <<< (STEPS_LOG2 + 1));
                d3_reg[i] <= six_a;
            end
            else if (advance)
            begin
                n_reg[i]  <= n_reg[i] + d1_reg[i];
                d1_reg[i] <= d1_reg[i] + d2_reg[i];
                d2_reg[i] <= d2_reg[i] + d3_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                out_coord_reg[i] <= pt[i];
            end
            out_clip_reg <= clip[0] || clip[1] || clip[2];
            out_last_reg <= last_k;
        end
    end

    assign curve_pts.valid      = out_valid_reg;
    assign curve_pts.curve_x    = out_coord_reg[0];
    assign curve_pts.curve_y    = out_coord_reg[1];
    assign curve_pts.curve_z    = out_coord_reg[2];
    assign curve_pts.clipped    = out_clip_reg;
    assign curve_pts.last_point = out_last_reg;

endmodule

// ===== sv/hermite_curve_point_generator.sv =====
`timescale 1ns / 1ps
// A segment beat passes the queue, the evaluator's load and the output register before
// its first point is on the output. The evaluator loads a segment only when idle, then emits
// 2^STEPS_LOG2 + 1 points, one per cycle while the output does not stall, before it loads another.
// The evaluator's single difference engine per axis sets that rate.
// Reset (asynchronous, active low) clears the stored pair, the queue and the output valid.
module hermite_curve_point_generator import hcpg_pkg::*; #(
    parameter int STEPS_LOG2 = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    hcpg_in_if.sink     ctrl_pts,
    hcpg_out_if.source  curve_pts
);

    // The front end stores each control point and its tangent. A beat that
    // follows a stored pair without a restart yields the coefficients
    // A = 2P0 - 2P1 + T0 + T1, B = 3P1 - 3P0 - 2T0 - T1, C = T0, D = P0 per axis.
    logic push;
    seg_t push_data;
    logic q_full;

    // The queue lets the front take the next beat while a segment is still
    // being drawn, so restarts and new points wait on the output only once the queue is full.
    logic q_valid;
    logic pop;
    seg_t q_data;

    hcpg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_pts  (ctrl_pts),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    hcpg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    // The back end steps u = k / 2^STEPS_LOG2 with exact integer forward
    // differences, so each point costs only adds. Every point passes through
    // an output register that holds it while the sink stalls.
    hcpg_back #(
        .STEPS_LOG2 (STEPS_LOG2)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .curve_pts (curve_pts)
    );

endmodule

// ===== verif/curve_point_checker.sv =====
`timescale 1ns / 1ps
// Checker for the cubic Hermite curve point generator: watches both channels,
// predicts the segment points and compares them beat by beat. Depends on hcpg_pkg, hcpg_in_if, hcpg_out_if.
module curve_point_checker import hcpg_pkg::*; #(
    parameter int STEPS_LOG2 = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    hcpg_in_if          ctrl_pts,
    hcpg_out_if         curve_pts,
    input  logic        drain_done,
    output int unsigned points_pending,
    output int unsigned fail_count
);

    localparam longint SEG_STEPS = longint'(1) << STEPS_LOG2;
    localparam longint SEG_STEPS2 = SEG_STEPS * SEG_STEPS;
    localparam longint SEG_STEPS3 = SEG_STEPS2 * SEG_STEPS;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   clipped;
        logic   last_point;
    } curve_point_t;

    coord_t       prev_point [3];
    coord_t       prev_tangent [3];
    logic         have_previous;
    logic         leftover_reported;
    int unsigned  mismatches;
    curve_point_t expected_points [$];

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic predict_segment();
        coord_t       new_point [3];
        coord_t       new_tangent [3];
        longint       seg_a [3];
        longint       seg_b [3];
        longint       seg_c [3];
        longint       seg_d [3];
        longint       num;
        longint       quot;
        coord_t       coord [3];
        logic         clip;
        curve_point_t pt;
        int           k;
        int           a;

        new_point[0] = ctrl_pts.point_x;
        new_point[1] = ctrl_pts.point_y;
        new_point[2] = ctrl_pts.point_z;
        new_tangent[0] = ctrl_pts.tangent_x;
        new_tangent[1] = ctrl_pts.tangent_y;
        new_tangent[2] = ctrl_pts.tangent_z;

        if (!ctrl_pts.start_new && have_previous)
        begin
            for (a = 0; a < AXES; a++)
            begin
                seg_a[a] = 2 * longint'(prev_point[a]) - 2 * longint'(new_point[a])
                         + longint'(prev_tangent[a]) + longint'(new_tangent[a]);
                seg_b[a] = -3 * longint'(prev_point[a]) + 3 * longint'(new_point[a])
                         - 2 * longint'(prev_tangent[a]) - longint'(new_tangent[a]);
                seg_c[a] = prev_tangent[a];
                seg_d[a] = prev_point[a];
            end
            for (k = 0; k <= SEG_STEPS; k++)
            begin
                clip = 1'b0;
                for (a = 0; a < AXES; a++)
                begin
                    num = seg_a[a] * k * k * k + seg_b[a] * k * k * SEG_STEPS
                        + seg_c[a] * k * SEG_STEPS2 + seg_d[a] * SEG_STEPS3;
                    // Signed division truncates toward zero, as the block must.
                    quot = num / SEG_STEPS3;
                    if (quot > COORD_MAX)
                    begin
                        quot = COORD_MAX;
                        clip = 1'b1;
                    end
                    else if (quot < COORD_MIN)
                    begin
                        quot = COORD_MIN;
                        clip = 1'b1;
                    end
                    coord[a] = coord_t'(quot);
                end
                pt.x = coord[0];
                pt.y = coord[1];
                pt.z = coord[2];
                pt.clipped = clip;
                pt.last_point = (k == SEG_STEPS);
                expected_points.push_back(pt);
            end
        end

        for (a = 0; a < AXES; a++)
        begin
            prev_point[a] = new_point[a];
            prev_tangent[a] = new_tangent[a];
        end
        have_previous = 1'b1;
    endtask

    task automatic check_point();
        curve_point_t want;

        if (expected_points.size() == 0)
        begin
            report_mismatch($sformatf("curve point (%0d,%0d,%0d) with none expected",
                                      curve_pts.curve_x, curve_pts.curve_y, curve_pts.curve_z));
            return;
        end
        want = expected_points.pop_front();
        if (curve_pts.curve_x !== want.x || curve_pts.curve_y !== want.y
                || curve_pts.curve_z !== want.z || curve_pts.clipped !== want.clipped
                || curve_pts.last_point !== want.last_point)
            report_mismatch($sformatf(
                "got (%0d,%0d,%0d) clip %b last %b, want (%0d,%0d,%0d) clip %b last %b",
                curve_pts.curve_x, curve_pts.curve_y, curve_pts.curve_z,
                curve_pts.clipped, curve_pts.last_point,
                want.x, want.y, want.z, want.clipped, want.last_point));
    endtask

    initial
    begin
        mismatches = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                prev_point[a] = '0;
                prev_tangent[a] = '0;
            end
            have_previous = 1'b0;
            leftover_reported = 1'b0;
            expected_points.delete();
        end
        else
        begin
            // Output beats belong to earlier segments, so compare before predicting.
            if (curve_pts.valid && curve_pts.ready)
                check_point();
            if (ctrl_pts.valid && ctrl_pts.ready)
                predict_segment();
            if (drain_done && !leftover_reported && expected_points.size() != 0)
            begin
                report_mismatch($sformatf("%0d curve points never arrived",
                                          expected_points.size()));
                leftover_reported = 1'b1;
            end
        end
        points_pending <= expected_points.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the cubic Hermite curve point generator: clock, reset,
// stimulus, output back-pressure and the verdict. Depends on hcpg_pkg, both channel
// interfaces, the generator itself and curve_point_checker.
module testbench import hcpg_pkg::*; ();

    // The default segment resolution: 33 points per segment.
    localparam int STEPS_LOG2 = 5;
    localparam int RANDOM_ITEMS = 465;
    localparam int PHASE_ITEMS = 155;
    // Long receiver hold-off, so that the segment queue fills and the input stalls.
    localparam int HOLD_CYCLES = 400;
    // Cycles after the last expected point.
    localparam int DRAIN_CYCLES = 40;
    // The slowest correct run goes quiet for the hold-off plus short random stalls;
    // the limit takes that several times over.
    localparam int WATCHDOG_LIMIT = 4000;

    // One control point beat as the stimulus sees it.
    typedef struct packed {
        logic   start_new;
        coord_t px;
        coord_t py;
        coord_t pz;
        coord_t tx;
        coord_t ty;
        coord_t tz;
    } ctrl_beat_t;

    logic        clk;
    logic        rst_n;
    logic        drain_done;
    logic        hold_request;
    int unsigned points_pending;
    int unsigned fail_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          stall_cycles;

    hcpg_in_if  ctrl_pts ();
    hcpg_out_if curve_pts ();

    hermite_curve_point_generator #(
        .STEPS_LOG2(STEPS_LOG2)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_pts  (ctrl_pts),
        .curve_pts (curve_pts)
    );

    curve_point_checker #(
        .STEPS_LOG2(STEPS_LOG2)
    ) point_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl_pts       (ctrl_pts),
        .curve_pts      (curve_pts),
        .drain_done     (drain_done),
        .points_pending (points_pending),
        .fail_count     (fail_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic ctrl_beat_t make_beat(input logic start_new, input int px,
                                             input int py, input int pz, input int tx,
                                             input int ty, input int tz);
        ctrl_beat_t b;

        b.start_new = start_new;
        b.px = coord_t'(px);
        b.py = coord_t'(py);
        b.pz = coord_t'(pz);
        b.tx = coord_t'(tx);
        b.ty = coord_t'(ty);
        b.tz = coord_t'(tz);
        return b;
    endfunction

    // Extremes often enough to force clamping, small values so that many curves
    // stay inside the range, and uniform values so that every bit toggles.
    function automatic coord_t random_coord();
        case ($urandom_range(7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return coord_t'(int'($urandom_range(64)) - 32);
            3: return coord_t'(int'($urandom_range(1000)) - 500);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Offers one beat, with random idle cycles in front of it, and returns at the
    // clock edge that accepts it. Ready is read just after the edge, before any
    // nonblocking update of that edge, so it is the value the block saw.
    task automatic offer_point(input ctrl_beat_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            ctrl_pts.valid <= 1'b0;
            @(posedge clk);
        end
        ctrl_pts.valid <= 1'b1;
        ctrl_pts.start_new <= b.start_new;
        ctrl_pts.point_x <= b.px;
        ctrl_pts.point_y <= b.py;
        ctrl_pts.point_z <= b.pz;
        ctrl_pts.tangent_x <= b.tx;
        ctrl_pts.tangent_y <= b.ty;
        ctrl_pts.tangent_z <= b.tz;
        @(posedge clk);
        while (!ctrl_pts.ready)
            @(posedge clk);
    endtask

    // Receiver: random back-pressure, or one long hold-off when the stimulus asks for
    // it. At most one update of ready per clock edge.
    initial
    begin
        curve_pts.ready <= 1'b0;
        hold_request <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                curve_pts.ready <= 1'b0;
                hold_request <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(posedge clk);
            end
            else
            begin
                curve_pts.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run once nothing has moved on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (ctrl_pts.valid && ctrl_pts.ready)
                || (curve_pts.valid && curve_pts.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        ctrl_beat_t b;

        rst_n <= 1'b0;
        drain_done <= 1'b0;
        stall_cycles <= 0;
        ctrl_pts.valid <= 1'b0;
        ctrl_pts.start_new <= 1'b0;
        ctrl_pts.point_x <= '0;
        ctrl_pts.point_y <= '0;
        ctrl_pts.point_z <= '0;
        ctrl_pts.tangent_x <= '0;
        ctrl_pts.tangent_y <= '0;
        ctrl_pts.tangent_z <= '0;
        // First phase: the sender idles a little, the receiver a lot.
        send_idle_pct = 18;
        recv_idle_pct = 80;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Right after reset no pair is stored, so a beat without the
        // start flag must still only store its pair.
        offer_point(make_beat(1'b0, 100, 200, -300, 5, 6, 7));
        offer_point(make_beat(1'b0, -100, 50, 2047, 0, 0, 0));
        // A restart in the middle of a curve drops the stored pair and emits nothing.
        offer_point(make_beat(1'b1, 0, 0, 0, 0, 0, 0));
        offer_point(make_beat(1'b0, 0, 0, 0, 0, 0, 0));
        offer_point(make_beat(1'b0, 2047, 2047, 2047, 2047, 2047, 2047));
        // Full swing from the top to the bottom: overshoots above the range first.
        offer_point(make_beat(1'b0, -2048, -2048, -2048, -2048, -2048, -2048));
        // From the bottom with a downward tangent: clamps at the low end.
        offer_point(make_beat(1'b0, 2047, 2047, 2047, -2048, -2048, -2048));
        // Two restarts in a row, then a curve that stays inside the range on every axis.
        offer_point(make_beat(1'b1, 2047, -2048, 0, 2047, 2047, 2047));
        offer_point(make_beat(1'b1, 1000, 0, 0, 2047, 0, 0));
        offer_point(make_beat(1'b0, 2000, 10, -10, 2047, 1, -1));
        // The same point twice with zero tangents gives a constant segment.
        offer_point(make_beat(1'b0, 2000, 10, -10, 0, 0, 0));
        offer_point(make_beat(1'b0, 2000, 10, -10, 0, 0, 0));
        // Mixed signs and odd values, where truncation toward zero matters.
        offer_point(make_beat(1'b0, -1, 1, -3, -7, 5, 3));
        offer_point(make_beat(1'b0, 3, -2, 1, 1, -1, -2047));
        offer_point(make_beat(1'b0, -2048, 2047, -2048, 2047, -2048, 2047));

        // Random part: mostly long curves with random content, with the odd restart.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == PHASE_ITEMS)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 18;
            end
            else if (n == 2 * PHASE_ITEMS)
            begin
                // Last phase: no idling, and one long hold-off on the output while
                // the sender keeps offering.
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request <= 1'b1;
            end
            b.start_new = ($urandom_range(99) < 6);
            b.px = random_coord();
            b.py = random_coord();
            b.pz = random_coord();
            b.tx = random_coord();
            b.ty = random_coord();
            b.tz = random_coord();
            offer_point(b);
        end
        ctrl_pts.valid <= 1'b0;

        // Let the checker count the last beat's points before points_pending is polled.
        @(posedge clk);
        while (points_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        drain_done <= 1'b1;
        repeat (2)
            @(posedge clk);

        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
